[sv/iub_pkg.sv]
// ----------------------------------------------------------------------------
// iub_pkg: shared types and constants of the integer upscale pixel blitter
// Request payloads, the queued pixel descriptor and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iub_pkg;

    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 24;
    localparam int COORD_W = 17;
    localparam int OFF_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IMG_W   = 13;
    localparam int REP_W   = 4;
    localparam int QUO_W   = 5;
    localparam int IDX_W   = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_DEPTH   = 2;

    localparam logic [CFG_W-1:0] SCREEN_W_RST = 16'd1024;
    localparam logic [CFG_W-1:0] SCREEN_H_RST = 16'd768;

    typedef logic [IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index REG_ORIGIN_X = 4'd0;
    localparam t_cfg_index REG_ORIGIN_Y = 4'd1;
    localparam t_cfg_index REG_TARGET_W = 4'd2;
    localparam t_cfg_index REG_TARGET_H = 4'd3;
    localparam t_cfg_index REG_IMAGE_W  = 4'd4;
    localparam t_cfg_index REG_IMAGE_H  = 4'd5;
    localparam t_cfg_index REG_SCREEN_W = 4'd6;
    localparam t_cfg_index REG_SCREEN_H = 4'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] byte2;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte0;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_out_item;

    // One accepted pixel as handed from the front end to the back end
    typedef struct packed {
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic [COLOR_W-1:0] color;
        logic [REP_W-1:0]   rep_x;
        logic [REP_W-1:0]   rows;
    } t_desc;

endpackage

[sv/iub_fifo.sv]
// ----------------------------------------------------------------------------
// iub_fifo: small synchronous queue
// Register-based first-in first-out store with full and empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iub_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store the incoming request
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[sv/iub_rep_div.sv]
// ----------------------------------------------------------------------------
// iub_rep_div: repeat factor divider
// Shift-subtract division of the limited target size by the image size for
// both axes at once, one quotient bit a cycle, saturated at the maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iub_rep_div #(
    parameter int EFF_W      = 13,
    parameter int MAX_REPEAT = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [1:0][iub_pkg::OFF_W-1:0]       i_lim,
    input  logic [1:0][EFF_W-1:0]                i_eff,
    input  logic [1:0]                           i_tzero,
    output logic                                 o_busy,
    output logic [1:0][iub_pkg::REP_W-1:0]       o_rep
);

    import iub_pkg::*;

    localparam int SH_W   = EFF_W + QUO_W - 1;
    localparam int CMP_W  = (SH_W > OFF_W) ? SH_W : OFF_W;
    localparam int STEP_W = $clog2(QUO_W);

    logic                    r_run;
    logic                    r_first;
    logic [STEP_W-1:0]       r_step;
    logic [1:0][OFF_W-1:0]   r_rem;
    logic [1:0][QUO_W-1:0]   r_q;
    logic [1:0][REP_W-1:0]   r_rep;

    logic [1:0][OFF_W-1:0]   cur_rem;
    logic [1:0][CMP_W-1:0]   shifted;
    logic [1:0][CMP_W-1:0]   diff;
    logic [1:0]              ge;
    logic [1:0][OFF_W-1:0]   n_rem;
    logic [1:0][QUO_W-1:0]   n_q;
    logic [1:0][REP_W-1:0]   fin;

    assign o_busy = r_run;
    assign o_rep  = r_rep;

    // One restoring step per lane, then saturate the quotient (one for a zero target)
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            cur_rem[l] = r_first ? i_lim[l] : r_rem[l];
            shifted[l] = CMP_W'(i_eff[l]) << r_step;
            diff[l]    = CMP_W'(cur_rem[l]) - shifted[l];
            ge[l]      = (CMP_W'(cur_rem[l]) >= shifted[l]);
            n_rem[l]   = ge[l] ? diff[l][OFF_W-1:0] : cur_rem[l];
            n_q[l]     = {r_q[l][QUO_W-2:0], ge[l]};
            if (i_tzero[l]) begin
                fin[l] = REP_W'(1);
            end else if (n_q[l] > QUO_W'(MAX_REPEAT)) begin
                fin[l] = REP_W'(MAX_REPEAT);
            end else begin
                fin[l] = n_q[l][REP_W-1:0];
            end
        end
    end

    // Sequence the quotient bits from the top down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_first <= 1'b0;
            r_step  <= '0;
            r_rep   <= {REP_W'(1), REP_W'(1)};
        end else if (i_start) begin
            r_run   <= 1'b1;
            r_first <= 1'b1;
            r_step  <= STEP_W'(QUO_W - 1);
            r_q     <= '0;
        end else if (r_run) begin
            r_first <= 1'b0;
            r_rem   <= n_rem;
            r_q     <= n_q;
            if (r_step == '0) begin
                r_run <= 1'b0;
                r_rep <= fin;
            end else begin
                r_step <= r_step - 1'b1;
            end
        end
    end

endmodule

[sv/iub_front.sv]
// ----------------------------------------------------------------------------
// iub_front: blitter front end
// Holds the registers, accepts pixels, tracks the image position and queues
// one descriptor per pixel that draws anything.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iub_front #(
    parameter int MAX_DIM    = 4096,
    parameter int MAX_REPEAT = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  iub_pkg::t_cfg_index         i_cfg_index,
    input  logic [iub_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_push,
    output logic                        o_full,
    input  iub_pkg::t_in_item           i_in,
    output logic                        o_desc_push,
    output iub_pkg::t_desc              o_desc,
    input  logic                        i_desc_full
);

    import iub_pkg::*;

    localparam int CNT_W     = ($clog2(MAX_DIM) < IMG_W) ? $clog2(MAX_DIM) : IMG_W;
    localparam int EFF_W     = CNT_W + 1;
    localparam int DIM_CMP_W = OFF_W + 1;

    logic [CFG_W-1:0] r_origin_x;
    logic [CFG_W-1:0] r_origin_y;
    logic [CFG_W-1:0] r_target_w;
    logic [CFG_W-1:0] r_target_h;
    logic [IMG_W-1:0] r_image_w;
    logic [IMG_W-1:0] r_image_h;
    logic [CFG_W-1:0] r_screen_w;
    logic [CFG_W-1:0] r_screen_h;

    logic [CNT_W-1:0] r_col_cnt;
    logic [CNT_W-1:0] r_row_cnt;
    logic [OFF_W-1:0] r_col_off;
    logic [OFF_W-1:0] r_row_off;
    logic [CNT_W-1:0] n_col_cnt;
    logic [CNT_W-1:0] n_row_cnt;
    logic [OFF_W-1:0] n_col_off;
    logic [OFF_W-1:0] n_row_off;

    logic                   cfg_we;
    logic                   div_busy;
    logic [1:0][OFF_W-1:0]  lim;
    logic [1:0][EFF_W-1:0]  eff;
    logic [1:0]             tzero;
    logic [1:0][REP_W-1:0]  rep;
    logic                   accept;
    logic [EFF_W-1:0]       col_inc;
    logic [EFF_W-1:0]       row_inc;

    // Clamp an image size to the range one to the largest dimension
    function automatic logic [EFF_W-1:0] eff_dim(input logic [IMG_W-1:0] d);
        logic [DIM_CMP_W-1:0] wide;
        wide = DIM_CMP_W'(d);
        if (d == '0) begin
            return EFF_W'(1);
        end else if (wide > DIM_CMP_W'(MAX_DIM)) begin
            return EFF_W'(MAX_DIM);
        end else begin
            return EFF_W'(d);
        end
    endfunction

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && (i_cfg_index <= REG_SCREEN_H);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_target_w <= '0;
            r_target_h <= '0;
            r_image_w  <= IMG_W'(1);
            r_image_h  <= IMG_W'(1);
            r_screen_w <= SCREEN_W_RST;
            r_screen_h <= SCREEN_H_RST;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_ORIGIN_X: r_origin_x <= i_cfg_data;
                REG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                REG_TARGET_W: r_target_w <= i_cfg_data;
                REG_TARGET_H: r_target_h <= i_cfg_data;
                REG_IMAGE_W:  r_image_w  <= i_cfg_data[IMG_W-1:0];
                REG_IMAGE_H:  r_image_h  <= i_cfg_data[IMG_W-1:0];
                REG_SCREEN_W: r_screen_w <= i_cfg_data;
                REG_SCREEN_H: r_screen_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Divider operands: limited target and clamped image size per axis
    always_comb begin
        lim[0]   = (r_target_w < r_screen_w) ? r_target_w : r_screen_w;
        lim[1]   = (r_target_h < r_screen_h) ? r_target_h : r_screen_h;
        eff[0]   = eff_dim(r_image_w);
        eff[1]   = eff_dim(r_image_h);
        tzero[0] = (r_target_w == '0);
        tzero[1] = (r_target_h == '0);
    end

    iub_rep_div #(
        .EFF_W      (EFF_W),
        .MAX_REPEAT (MAX_REPEAT)
    ) u_rep_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cfg_we),
        .i_lim   (lim),
        .i_eff   (eff),
        .i_tzero (tzero),
        .o_busy  (div_busy),
        .o_rep   (rep)
    );

    // Hold off requests while the factors are recomputed, a register write is offered or the queue is full
    assign o_full      = div_busy || i_desc_full || i_cfg_valid;
    assign accept      = i_push && !o_full;
    assign o_desc_push = accept && (rep[0] != '0);

    // Build the descriptor for the back end
    always_comb begin
        o_desc.base_x = {1'b0, r_origin_x} + {1'b0, r_col_off};
        o_desc.base_y = {1'b0, r_origin_y} + {1'b0, r_row_off};
        o_desc.color  = {i_in.byte2, i_in.byte1, i_in.byte0};
        o_desc.rep_x  = rep[0];
        o_desc.rows   = (rep[1] == '0) ? REP_W'(1) : rep[1];
    end

    // Advance the position through the image
    always_comb begin
        col_inc   = {1'b0, r_col_cnt} + 1'b1;
        row_inc   = {1'b0, r_row_cnt} + 1'b1;
        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        n_col_off = r_col_off;
        n_row_off = r_row_off;
        if (accept) begin
            n_col_off = r_col_off + OFF_W'(rep[0]);
            if (col_inc >= eff[0]) begin
                n_col_cnt = '0;
                n_col_off = '0;
                n_row_off = r_row_off + OFF_W'(rep[1]);
                if (row_inc >= eff[1]) begin
                    n_row_cnt = '0;
                    n_row_off = '0;
                end else begin
                    n_row_cnt = row_inc[CNT_W-1:0];
                end
            end else begin
                n_col_cnt = col_inc[CNT_W-1:0];
            end
        end
    end

    // Restart at the top-left corner on reset or any write to a mapped register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_col_off <= '0;
            r_row_off <= '0;
        end else begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
            r_col_off <= n_col_off;
            r_row_off <= n_row_off;
        end
    end

endmodule

[sv/iub_back.sv]
// ----------------------------------------------------------------------------
// iub_back: blitter back end
// Expands one queued pixel into its block of frame-buffer writes, one write
// a cycle while the output queue has room, columns outer and rows inner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iub_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_desc_valid,
    input  iub_pkg::t_desc     i_desc,
    output logic               o_desc_pop,
    input  logic               i_out_full,
    output logic               o_out_push,
    output iub_pkg::t_out_item o_out
);

    import iub_pkg::*;

    logic             r_busy;
    t_desc            r_cur;
    logic [REP_W-1:0] r_i;
    logic [REP_W-1:0] r_j;
    logic             emit;
    logic             col_end;
    logic             row_end;
    logic             is_last;

    assign emit       = r_busy && !i_out_full;
    assign row_end    = ((r_j + 1'b1) == r_cur.rows);
    assign col_end    = ((r_i + 1'b1) == r_cur.rep_x);
    assign is_last    = row_end && col_end;
    assign o_desc_pop = i_desc_valid && (!r_busy || (emit && is_last));
    assign o_out_push = emit;

    // Form the current write
    always_comb begin
        o_out.pixel_x = r_cur.base_x + COORD_W'(r_i);
        o_out.pixel_y = r_cur.base_y + COORD_W'(r_j);
        o_out.color   = r_cur.color;
        o_out.last    = is_last;
    end

    // Load the next pixel or advance through the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_desc_pop) begin
            r_busy <= 1'b1;
            r_cur  <= i_desc;
            r_i    <= '0;
            r_j    <= '0;
        end else if (emit) begin
            if (is_last) begin
                r_busy <= 1'b0;
            end else if (row_end) begin
                r_j <= '0;
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

endmodule

[sv/integer_upscale_pixel_blitter.sv]
// ----------------------------------------------------------------------------
// integer_upscale_pixel_blitter: nearest-neighbour integer upscale blitter
// Takes 3-byte pixels in drawing order, top row first, and gives one
// frame-buffer write for every screen position of the pixel's repeat block,
// rep_x by max(rep_y,1), with last set on the final write of each pixel. The
// back end gives one write a cycle while the output queue has room; a pixel
// whose horizontal factor is zero gives no write. The front end accepts a
// pixel every cycle while its two-entry descriptor queue has room, the
// divider is idle and no register write is offered, and a two-entry output
// queue lets the back end keep going while a write waits to be popped. After
// every write to a mapped register the repeat factors come from a
// shift-subtract divider, one quotient bit a cycle; full stays high while it
// runs and the position restarts at the image's top-left corner. The
// configuration port is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_upscale_pixel_blitter #(
    parameter int MAX_DIM    = 4096,
    parameter int MAX_REPEAT = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  iub_pkg::t_cfg_index         i_cfg_index,
    input  logic [iub_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  iub_pkg::t_in_item           i_in,
    output logic                        empty,
    input  logic                        pop,
    output iub_pkg::t_out_item          o_out
);

    import iub_pkg::*;

    logic      desc_push;
    t_desc     desc_in;
    logic      desc_full;
    t_desc     desc_head;
    logic      desc_empty;
    logic      desc_pop;
    logic      out_push;
    t_out_item out_item;
    logic      out_full;

    // Accept and classify pixels
    iub_front #(
        .MAX_DIM    (MAX_DIM),
        .MAX_REPEAT (MAX_REPEAT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_full      (full),
        .i_in        (i_in),
        .o_desc_push (desc_push),
        .o_desc      (desc_in),
        .i_desc_full (desc_full)
    );

    // Decouple front and back ends
    iub_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_desc))
    ) u_desc_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_data  (desc_in),
        .o_full  (desc_full),
        .i_pop   (desc_pop),
        .o_data  (desc_head),
        .o_empty (desc_empty)
    );

    // Expand each pixel into its writes
    iub_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (!desc_empty),
        .i_desc       (desc_head),
        .o_desc_pop   (desc_pop),
        .i_out_full   (out_full),
        .o_out_push   (out_push),
        .o_out        (out_item)
    );

    // Hold writes until popped
    iub_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(t_out_item))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_item),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );

endmodule

[dv/integer_upscale_pixel_blitter_tb.sv]
// ----------------------------------------------------------------------------
// integer_upscale_pixel_blitter_tb: self-checking bench for the upscale blitter
// Feeds 3-byte pixels into the blitter under several register
// settings, predicts every frame-buffer write of each repeat block and checks
// each popped write in order against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_upscale_pixel_blitter_tb;

    import iub_pkg::*;

    localparam int          MAX_DIM       = 4096;
    localparam int          MAX_REPEAT    = 8;
    localparam int          IDLE_PERCENT  = 21;
    localparam int          RESET_CYCLES  = 10;
    localparam int          DRAIN_CYCLES  = 32;
    localparam int          RANDOM_ITEMS  = 150;
    localparam longint      TIMEOUT_NS    = 4_000_000;
    localparam t_cfg_index  UNMAPPED_FIRST = 4'd8;
    localparam t_cfg_index  UNMAPPED_LAST  = 4'd15;
    localparam logic [CFG_W-1:0] IMAGE_MASK = {{(CFG_W-IMG_W){1'b0}}, {IMG_W{1'b1}}};

    // ------------------------------------------------------------------------
    // Write predictor and in-order checker
    // ------------------------------------------------------------------------
    class blit_scoreboard;
        logic [CFG_W-1:0] regs [8];
        int unsigned      column_count;
        int unsigned      row_count;
        logic [OFF_W-1:0] column_offset;
        logic [OFF_W-1:0] row_offset;
        int unsigned      rep_x;
        int unsigned      rep_y;
        t_out_item        pending_writes [$];
        int unsigned      errors;
        int unsigned      writes_checked;
        int unsigned      pixels_seen;
        int unsigned      blank_pixels;

        // Clamp an image dimension into 1 .. MAX_DIM
        function int unsigned effective_size(input logic [CFG_W-1:0] d);
            if (d == 0) return 1;
            if (d > MAX_DIM) return MAX_DIM;
            return d;
        endfunction

        function int unsigned repeat_factor(input logic [CFG_W-1:0] target, screen, img);
            int unsigned span;
            int unsigned q;
            if (target == 0) return 1;
            span = (target < screen) ? target : screen;
            q = span / effective_size(img);
            return (q > MAX_REPEAT) ? MAX_REPEAT : q;
        endfunction

        function void restart_position();
            rep_x = repeat_factor(regs[REG_TARGET_W], regs[REG_SCREEN_W], regs[REG_IMAGE_W]);
            rep_y = repeat_factor(regs[REG_TARGET_H], regs[REG_SCREEN_H], regs[REG_IMAGE_H]);
            column_count  = 0;
            row_count     = 0;
            column_offset = '0;
            row_offset    = '0;
        endfunction

        function void power_on();
            regs[REG_ORIGIN_X] = '0;
            regs[REG_ORIGIN_Y] = '0;
            regs[REG_TARGET_W] = '0;
            regs[REG_TARGET_H] = '0;
            regs[REG_IMAGE_W]  = 1;
            regs[REG_IMAGE_H]  = 1;
            regs[REG_SCREEN_W] = SCREEN_W_RST;
            regs[REG_SCREEN_H] = SCREEN_H_RST;
            restart_position();
            pending_writes.delete();
            errors         = 0;
            writes_checked = 0;
            pixels_seen    = 0;
            blank_pixels   = 0;
        endfunction

        // Unmapped indexes leave both settings and position untouched
        function void apply_register(input t_cfg_index idx, input logic [CFG_W-1:0] data);
            if (idx > REG_SCREEN_H) return;
            if (idx == REG_IMAGE_W || idx == REG_IMAGE_H) begin
                regs[idx] = data & IMAGE_MASK;
            end else begin
                regs[idx] = data;
            end
            restart_position();
        endfunction

        // Queue the writes of one repeat block, then advance the position
        function void note_pixel(input t_in_item px);
            t_out_item   w;
            int unsigned rows;
            int unsigned total;
            int unsigned n;
            int unsigned sum_x;
            int unsigned sum_y;
            rows  = (rep_y == 0) ? 1 : rep_y;
            total = rep_x * rows;
            n     = 0;
            for (int unsigned i = 0; i < rep_x; i++) begin
                for (int unsigned j = 0; j < rows; j++) begin
                    sum_x     = regs[REG_ORIGIN_X] + column_offset + i;
                    sum_y     = regs[REG_ORIGIN_Y] + row_offset + j;
                    w.pixel_x = sum_x[COORD_W-1:0];
                    w.pixel_y = sum_y[COORD_W-1:0];
                    w.color   = {px.byte2, px.byte1, px.byte0};
                    w.last    = (n + 1 == total);
                    pending_writes.push_back(w);
                    n++;
                end
            end
            pixels_seen++;
            if (total == 0) blank_pixels++;

            column_offset = column_offset + OFF_W'(rep_x);
            column_count++;
            if (column_count >= effective_size(regs[REG_IMAGE_W])) begin
                column_count  = 0;
                column_offset = '0;
                row_offset    = row_offset + OFF_W'(rep_y);
                row_count++;
                if (row_count >= effective_size(regs[REG_IMAGE_H])) begin
                    row_count  = 0;
                    row_offset = '0;
                end
            end
        endfunction

        function void flag(input string what);
            $display("[%0t] %s", $time, what);
            errors++;
        endfunction

        function void compare_field(input string name, input logic [31:0] want, got);
            if (got !== want) begin
                flag($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
            end
        endfunction

        function void check_write(input t_out_item got);
            t_out_item want;
            if (pending_writes.size() == 0) begin
                flag($sformatf("write with none expected: expected nothing, got x=%0h y=%0h c=%0h l=%0b",
                               got.pixel_x, got.pixel_y, got.color, got.last));
                return;
            end
            want = pending_writes.pop_front();
            writes_checked++;
            compare_field("pixel_x", want.pixel_x, got.pixel_x);
            compare_field("pixel_y", want.pixel_y, got.pixel_y);
            compare_field("color", want.color, got.color);
            compare_field("last", want.last, got.last);
        endfunction

        function int unsigned pending_count();
            return pending_writes.size();
        endfunction

        function void finish_check();
            if (pending_writes.size() != 0) begin
                flag($sformatf("writes never seen: expected %0d more, got 0",
                               pending_writes.size()));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, signals and block under test
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    t_cfg_index       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             push;
    logic             full;
    t_in_item         pixel_in;
    logic             empty;
    logic             pop;
    t_out_item        write_out;

    blit_scoreboard   sb;
    bit               steady_flow;
    int unsigned      settings_done;

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    integer_upscale_pixel_blitter u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .push        (push),
        .full        (full),
        .i_in        (pixel_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (write_out)
    );

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    function automatic bit idle_now();
        return !steady_flow && ($urandom_range(0, 99) < IDLE_PERCENT);
    endfunction

    function automatic t_in_item random_pixel();
        logic [31:0] r;
        r = $urandom;
        return r[COLOR_W-1:0];
    endfunction

    // Mostly tiny images so rows and frames wrap often; now and then zero or
    // a random full-width value that may have the upper data bits set
    function automatic logic [CFG_W-1:0] random_image_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Aim at a repeat factor, with a random remainder that must be dropped
    function automatic logic [CFG_W-1:0] random_target(input logic [CFG_W-1:0] img);
        int unsigned span;
        int unsigned reps;
        span = sb.effective_size(img);
        if ($urandom_range(0, 4) == 0) return '0;
        reps = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
        span = reps * span + $urandom_range(0, span - 1);
        return (span > 16'hFFFF) ? 16'hFFFF : CFG_W'(span);
    endfunction

    function automatic logic [CFG_W-1:0] random_screen();
        return ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(1, 16'hFFFF)) : 16'hFFFF;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers: inputs move on the falling edge, handshakes seen on the rising
    // ------------------------------------------------------------------------
    task automatic send_pixel(input t_in_item px);
        while (idle_now()) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push     <= 1'b1;
        pixel_in <= px;
        do @(posedge clk); while (full !== 1'b0);
        sb.note_pixel(px);
        @(negedge clk);
    endtask

    task automatic send_burst(input int unsigned count);
        repeat (count) send_pixel(random_pixel());
    endtask

    // Hold until every write has been popped, then let the tail of the pipe
    // (blank pixels, divider) run out
    task automatic settle();
        push <= 1'b0;
        while (sb.pending_count() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Leaves valid high so back-to-back writes need only one drive per edge
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.apply_register(idx, data);
        @(negedge clk);
    endtask

    task automatic program_all(input logic [CFG_W-1:0] ox, oy, tw, th, iw, ih, sw, sh);
        settle();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_TARGET_W, tw);
        write_reg(REG_TARGET_H, th);
        write_reg(REG_IMAGE_W, iw);
        write_reg(REG_IMAGE_H, ih);
        write_reg(REG_SCREEN_W, sw);
        write_reg(REG_SCREEN_H, sh);
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    task automatic poke_unmapped();
        settle();
        write_reg(t_cfg_index'($urandom_range(UNMAPPED_FIRST, UNMAPPED_LAST)), CFG_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_setup();
        logic [CFG_W-1:0] iw;
        logic [CFG_W-1:0] ih;
        iw = random_image_size();
        ih = random_image_size();
        program_all(CFG_W'($urandom), CFG_W'($urandom), random_target(iw), random_target(ih),
                    iw, ih, random_screen(), random_screen());
    endtask

    // Drain side: pop at random, except in the steady stretch
    always @(negedge clk) begin
        pop <= rst_n && !idle_now();
    end

    // Check every popped write
    always @(posedge clk) begin
        if (rst_n && pop && !empty) sb.check_write(write_out);
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned random_items;
        int unsigned phase;
        int unsigned count;
        int unsigned frame;

        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pixel_in      = '0;
        steady_flow   = 1'b0;
        settings_done = 0;
        random_items  = 0;
        phase         = 0;
        sb = new;
        sb.power_on();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: one write per pixel, colour extremes
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h5AA55A);

        // Zero image size, largest origin and targets: saturated 8x8 blocks
        program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0, '0, 16'hFFFF, 16'hFFFF);
        send_burst(2);

        // Zero horizontal factor: no writes, position still advances
        program_all(16'd10, 16'd20, 16'd3, '0, 16'd4, 16'd2, 16'd1024, 16'd768);
        send_burst(4);

        // Zero vertical factor, height limited by the screen
        program_all(16'd7, 16'd9, '0, 16'd500, 16'd2, 16'd6, 16'd1024, 16'd5);
        send_burst(6);

        // Oversized image dimensions, upper data bits dropped
        program_all(16'd300, 16'd400, 16'hFFFF, 16'd20000, 16'hFFFF, 16'd5000,
                    16'hFFFF, 16'hFFFF);
        send_burst(2);

        // Typical 2x2 upscale across a row end; unmapped write mid-image
        program_all(16'd100, 16'd200, 16'd8, 16'd6, 16'd4, 16'd3, 16'd1024, 16'd768);
        send_burst(3);
        poke_unmapped();
        send_burst(3);

        // Random settings, mostly whole frames of random pixels
        while (random_items < RANDOM_ITEMS) begin
            phase++;
            steady_flow = (phase >= 4 && phase < 8);
            case ($urandom_range(0, 5))
                0: settle();
                1: begin
                    random_setup();
                    poke_unmapped();
                end
                default: random_setup();
            endcase
            frame = sb.effective_size(sb.regs[REG_IMAGE_W]) *
                    sb.effective_size(sb.regs[REG_IMAGE_H]);
            count = ($urandom_range(0, 2) != 0 && frame <= 36) ? frame : $urandom_range(3, 16);
            send_burst(count);
            random_items += count;
        end
        steady_flow = 1'b0;

        settle();
        sb.finish_check();
        $display("Sent %0d pixels (%0d with a zero factor) over %0d register settings",
                 sb.pixels_seen, sb.blank_pixels, settings_done);
        $display("Checked %0d frame-buffer writes, %0d mismatches",
                 sb.writes_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d writes outstanding", sb.pending_count());
        $display("== FAIL ==");
        $finish;
    end

endmodule
